// ----- hw/rtl/raeu_pkg.sv -----
// Shared types, codes and constants of the register ALU execute unit.
`default_nettype none

package raeu_pkg;

    // Sizes of the register file, the decode queue, the bus words, the data word, the index fields and the flags.
    localparam int RAEU_NUM_REGS    = 8;
    localparam int RAEU_QUEUE_DEPTH = 2;
    localparam int RAEU_IN_TDATA_W  = 32;
    localparam int RAEU_OUT_TDATA_W = 40;
    localparam int RAEU_OUT_TUSER_W = 2;
    localparam int RAEU_DATA_W      = 16;
    localparam int RAEU_FIELD_IDX_W = 4;
    localparam int RAEU_FLAGS_W     = 4;

    // Bit positions inside the status flags.
    localparam int FLAG_Z_BIT = 0;
    localparam int FLAG_O_BIT = 1;
    localparam int FLAG_C_BIT = 2;
    localparam int FLAG_N_BIT = 3;

    // The not instruction must name this source field.
    localparam logic [RAEU_FIELD_IDX_W-1:0] NOT_SRC_CODE = 4'd15;

    // Instruction modes.
    typedef enum logic [3:0] {
        MODE_ADD  = 4'd0,
        MODE_SUB  = 4'd1,
        MODE_MUL  = 4'd2,
        MODE_DIV  = 4'd3,
        MODE_CMP  = 4'd4,
        MODE_NOT  = 4'd5,
        MODE_AND  = 4'd6,
        MODE_OR   = 4'd7,
        MODE_XOR  = 4'd8,
        MODE_TEST = 4'd9,
        MODE_SHL  = 4'd10,
        MODE_SHR  = 4'd11,
        MODE_XCHG = 4'd12,
        MODE_LDI  = 4'd13
    } t_mode;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_SWAP
    } t_state;

    // One decoded instruction as it travels through the queue.
    typedef struct packed {
        t_mode                       mode;
        logic [RAEU_FIELD_IDX_W-1:0] dst;
        logic [RAEU_FIELD_IDX_W-1:0] src;
        logic [RAEU_DATA_W-1:0]      imm;
        logic                        ok;
        logic                        dvalid;
        logic                        svalid;
    } t_op;

endpackage

`default_nettype wire

// ----- hw/rtl/raeu_front.sv -----
// Front end: unpacks an input beat and classifies the instruction.
`default_nettype none

module raeu_front
    import raeu_pkg::*;
#(
    parameter int NUM_REGS = RAEU_NUM_REGS
) (
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // mode[3:0], dst_index[7:4], src_index[11:8], immediate[27:12], zero pad
    input  wire logic [RAEU_IN_TDATA_W-1:0] i_s_axis_tdata,
    input  wire logic                       i_q_full,
    output logic                            o_push,
    output t_op                             o_op
);

    localparam logic [RAEU_FIELD_IDX_W:0] REGS_LIMIT = (RAEU_FIELD_IDX_W+1)'(NUM_REGS);

    logic [3:0]                  mode_bits;
    logic [RAEU_FIELD_IDX_W-1:0] dst;
    logic [RAEU_FIELD_IDX_W-1:0] src;
    logic                        dvalid;
    logic                        svalid;
    logic                        ok;

    // Field extraction and index range checks.
    assign mode_bits = i_s_axis_tdata[3:0];
    assign dst       = i_s_axis_tdata[7:4];
    assign src       = i_s_axis_tdata[11:8];
    assign dvalid    = {1'b0, dst} < REGS_LIMIT;
    assign svalid    = {1'b0, src} < REGS_LIMIT;

    // Decide whether the instruction will execute at all.
    always_comb begin
        unique case (mode_bits)
            MODE_NOT: ok = dvalid && (src == NOT_SRC_CODE);
            MODE_LDI: ok = dvalid;
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_CMP, MODE_AND, MODE_OR,
            MODE_XOR, MODE_TEST, MODE_SHL, MODE_SHR, MODE_XCHG:
                ok = dvalid && svalid;
            default: ok = 1'b0;
        endcase
    end

    // A beat enters whenever the queue has room.
    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_op.mode   = t_mode'(mode_bits);
        o_op.dst    = dst;
        o_op.src    = src;
        o_op.imm    = i_s_axis_tdata[27:12];
        o_op.ok     = ok;
        o_op.dvalid = dvalid;
        o_op.svalid = svalid;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/raeu_queue.sv -----
// Short queue of decoded instructions between the front and back ends.
`default_nettype none

module raeu_queue
    import raeu_pkg::*;
#(
    parameter int DEPTH = RAEU_QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_op       o_op
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_op              r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_en;
    logic             pop_en;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    // Storage slots.
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + 1'b1;
            end else if (pop_en && !push_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/raeu_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module raeu_div
    import raeu_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [RAEU_DATA_W-1:0] i_dividend,
    input  wire logic [RAEU_DATA_W-1:0] i_divisor,
    output logic                        o_busy,
    output logic [RAEU_DATA_W-1:0]      o_quotient
);

    localparam int STEPS = RAEU_DATA_W;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_START = CNT_W'(STEPS);

    logic                   r_busy;
    logic [CNT_W-1:0]       r_cnt;
    logic [RAEU_DATA_W-1:0] r_rem;
    logic [RAEU_DATA_W-1:0] r_quo;
    logic [RAEU_DATA_W-1:0] r_den;
    logic                   r_neg;
    logic [RAEU_DATA_W:0]   shifted;
    logic [RAEU_DATA_W+1:0] diff;

    // Shift in the next dividend bit and trial-subtract the divisor.
    assign shifted = {r_rem, r_quo[RAEU_DATA_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};

    // Datapath: magnitudes are divided, the sign is applied at the end.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[RAEU_DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_den <= i_divisor[RAEU_DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_neg <= i_dividend[RAEU_DATA_W-1] ^ i_divisor[RAEU_DATA_W-1];
        end else if (r_busy) begin
            if (!diff[RAEU_DATA_W+1]) begin
                r_rem <= diff[RAEU_DATA_W-1:0];
                r_quo <= {r_quo[RAEU_DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[RAEU_DATA_W-1:0];
                r_quo <= {r_quo[RAEU_DATA_W-2:0], 1'b0};
            end
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_START;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != CNT_W'(1));
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

// ----- hw/rtl/raeu_back.sv -----
// Back end: register file, ALU, flag register, sequencer and output register.
`default_nettype none

module raeu_back
    import raeu_pkg::*;
#(
    parameter int NUM_REGS = RAEU_NUM_REGS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_op_valid,
    input  wire t_op                         i_op,
    output logic                             o_pop,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // dst_value[15:0], src_value[31:16], flags[35:32], zero pad
    output logic [RAEU_OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // accepted[0], divide_error[1]
    output logic [RAEU_OUT_TUSER_W-1:0]      o_m_axis_tuser
);

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int W     = RAEU_DATA_W;
    localparam int PAD_W = RAEU_OUT_TDATA_W - 2 * W - RAEU_FLAGS_W;

    // Register file with per-entry written bits standing in for the reset.
    logic [W-1:0]        mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_written;
    logic [W-1:0]        r_rd_d;
    logic [W-1:0]        r_rd_s;
    logic                r_rd_d_wr;
    logic                r_rd_s_wr;

    t_state              r_state;
    t_state              n_state;
    t_op                 r_op;
    logic [RAEU_FLAGS_W-1:0] r_flags;
    logic [RAEU_FLAGS_W-1:0] n_flags;
    logic                r_out_valid;
    logic [RAEU_OUT_TDATA_W-1:0] r_out_data;
    logic [RAEU_OUT_TUSER_W-1:0] r_out_user;

    logic                out_free;
    logic                mem_we;
    logic                wr_src;
    logic                flag_we;
    logic                out_load;
    logic                div_start;
    logic                div_go;
    logic                div_busy;
    logic [W-1:0]        div_q;
    logic [IDX_W-1:0]    waddr;
    logic [W-1:0]        wdata;
    logic [IDX_W-1:0]    rd_dst_idx;
    logic [IDX_W-1:0]    rd_src_idx;

    logic [W-1:0]        d;
    logic [W-1:0]        s;
    logic [W-1:0]        alu_val;
    logic [W-1:0]        wb_val;
    logic [W-1:0]        diff;
    logic [2*W-1:0]      prod;
    logic [W-1:0]        tst;
    logic [W-1:0]        shl_val;
    logic [W-1:0]        shr_val;
    logic                big_shift;
    logic [3:0]          shl_cbit;
    logic [3:0]          shr_cbit;
    logic                shl_c;
    logic                shr_c;
    logic                d_pos;
    logic                s_pos;
    logic                t_pos;
    logic                cmp_o;
    logic                dverr;
    logic [W-1:0]        dst_out;
    logic [W-1:0]        src_out;

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign rd_dst_idx = i_op.dst[IDX_W-1:0];
    assign rd_src_idx = i_op.src[IDX_W-1:0];

    // Registered operand reads, taken as the instruction leaves the queue.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op      <= i_op;
            r_rd_d    <= mem[rd_dst_idx];
            r_rd_s    <= mem[rd_src_idx];
            r_rd_d_wr <= r_written[rd_dst_idx];
            r_rd_s_wr <= r_written[rd_src_idx];
        end
    end

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (mem_we) begin
            r_written[waddr] <= 1'b1;
        end
    end

    // Operands; an entry never written reads as zero.
    assign d = (r_op.dvalid && r_rd_d_wr) ? r_rd_d : '0;
    assign s = (r_op.svalid && r_rd_s_wr) ? r_rd_s : '0;

    // Shared arithmetic terms.
    assign diff      = d - s;
    assign prod      = d * s;
    assign tst       = d & s;
    assign big_shift = (s >= W'(W));
    assign shl_val   = big_shift ? '0 : (d << s[3:0]);
    assign shr_val   = big_shift ? {W{d[W-1]}} : W'($signed(d) >>> s[3:0]);
    assign shl_cbit  = 4'(5'd16 - s[4:0]);
    assign shr_cbit  = s[3:0] - 4'd1;
    assign shl_c     = (s >= W'(1)) && (s <= W'(W)) && d[shl_cbit];
    assign shr_c     = (s >= W'(1)) && (s < W'(W)) && d[shr_cbit];
    assign d_pos     = !d[W-1] && (d != '0);
    assign s_pos     = !s[W-1] && (s != '0);
    assign t_pos     = !diff[W-1] && (diff != '0);
    assign cmp_o     = (s[W-1] && d_pos && diff[W-1]) || (s_pos && d[W-1] && t_pos);
    assign dverr     = r_op.ok && (r_op.mode == MODE_DIV) && (s == '0);
    assign div_go    = r_op.ok && (r_op.mode == MODE_DIV) && (s != '0);

    // ALU result and flag update.
    always_comb begin
        alu_val = d;
        n_flags = r_flags;
        unique case (r_op.mode)
            MODE_ADD:  alu_val = d + s;
            MODE_SUB:  alu_val = diff;
            MODE_MUL:  alu_val = prod[W-1:0];
            MODE_DIV:  alu_val = d;
            MODE_CMP: begin
                n_flags[FLAG_Z_BIT] = (diff == '0);
                n_flags[FLAG_N_BIT] = diff[W-1];
                n_flags[FLAG_C_BIT] = (s > d);
                n_flags[FLAG_O_BIT] = cmp_o;
            end
            MODE_NOT:  alu_val = ~d;
            MODE_AND:  alu_val = d & s;
            MODE_OR:   alu_val = d | s;
            MODE_XOR:  alu_val = d ^ s;
            MODE_TEST: begin
                if (tst == '0) n_flags[FLAG_Z_BIT] = 1'b1;
                if (tst[W-1])  n_flags[FLAG_N_BIT] = 1'b1;
            end
            MODE_SHL: begin
                alu_val = shl_val;
                if (shl_c)          n_flags[FLAG_C_BIT] = 1'b1;
                if (shl_val == '0)  n_flags[FLAG_Z_BIT] = 1'b1;
                if (shl_val[W-1])   n_flags[FLAG_N_BIT] = 1'b1;
            end
            MODE_SHR: begin
                alu_val = shr_val;
                if (shr_c)          n_flags[FLAG_C_BIT] = 1'b1;
                if (shr_val == '0)  n_flags[FLAG_Z_BIT] = 1'b1;
                if (shr_val[W-1])   n_flags[FLAG_N_BIT] = 1'b1;
            end
            MODE_XCHG: alu_val = s;
            MODE_LDI:  alu_val = r_op.imm;
            default:   alu_val = d;
        endcase
    end

    // Value written back and reported for the destination.
    assign wb_val  = (r_state == ST_DIV) ? div_q : alu_val;
    assign dst_out = !r_op.dvalid ? '0 : (r_op.ok ? wb_val : d);
    assign src_out = !r_op.svalid ? '0 :
                     (r_op.ok && (r_op.mode == MODE_XCHG)) ? d :
                     (r_op.ok && (r_op.src == r_op.dst)) ? wb_val : s;
    assign waddr   = wr_src ? r_op.src[IDX_W-1:0] : r_op.dst[IDX_W-1:0];
    assign wdata   = wr_src ? d : wb_val;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_op_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (div_go) begin
                    n_state = ST_DIV;
                end else if (out_free) begin
                    n_state = (r_op.ok && (r_op.mode == MODE_XCHG)) ? ST_SWAP : ST_IDLE;
                end
            end
            ST_DIV: begin
                if (!div_busy && out_free) n_state = ST_IDLE;
            end
            ST_SWAP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_pop     = 1'b0;
        mem_we    = 1'b0;
        wr_src    = 1'b0;
        flag_we   = 1'b0;
        out_load  = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop = i_op_valid;
            ST_EXEC: begin
                div_start = div_go;
                if (!div_go && out_free) begin
                    out_load = 1'b1;
                    mem_we   = r_op.ok;
                    flag_we  = r_op.ok;
                end
            end
            ST_DIV: begin
                if (!div_busy && out_free) begin
                    out_load = 1'b1;
                    mem_we   = 1'b1;
                end
            end
            ST_SWAP: begin
                mem_we = 1'b1;
                wr_src = 1'b1;
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            if (flag_we) r_flags <= n_flags;
        end
    end

    // Output register; the flags shown are those after this instruction.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, (flag_we ? n_flags : r_flags), src_out, dst_out};
            r_out_user <= {dverr, r_op.ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    raeu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (d),
        .i_divisor  (s),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    // The divider is always finished by the time the sequencer is idle.
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !div_busy)
        else $error("divider still busy while sequencer idle");

    // The second write of an exchange follows a completed first write.
    a_swap_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWAP |-> $past(r_state) == ST_EXEC && $past(out_load))
        else $error("exchange write-back out of sequence");

    // Entering the divide wait means the divider has been started.
    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && $past(r_state) == ST_EXEC) |-> div_busy)
        else $error("divide wait entered without a running divider");

    // Flags change only on an executed flag update.
    a_flags_guarded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_flags)) |-> $past(flag_we))
        else $error("status flags changed without an update");

endmodule

`default_nettype wire

// ----- hw/rtl/register_alu_execute_unit.sv -----
// An accepted input beat waits in the queue; the back end reads its operands as it leaves
// the queue, then executes it into the output register. An exchange adds a second
// write-back step, and a division waits for the divider's 16 steps. The back end takes
// one instruction at a time and finishes one only when the output register is free.
// Reset is synchronous and active low: the register file reads as zero, the flags
// clear, the queue and the output register empty.
`default_nettype none

module register_alu_execute_unit
    import raeu_pkg::*;
#(
    parameter int NUM_REGS = RAEU_NUM_REGS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // mode[3:0], dst_index[7:4], src_index[11:8], immediate[27:12], zero pad
    input  wire logic [RAEU_IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  wire logic                        i_m_axis_tready,
    // dst_value[15:0], src_value[31:16], flags[35:32], zero pad
    output logic [RAEU_OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // accepted[0], divide_error[1]
    output logic [RAEU_OUT_TUSER_W-1:0]      o_m_axis_tuser
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_op  front_op;
    t_op  queue_op;

    // Decode of incoming beats.
    raeu_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_op            (front_op)
    );

    // Decoupling queue.
    raeu_queue #(
        .DEPTH (RAEU_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_op    (queue_op)
    );

    // Execution against the register file.
    raeu_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op_valid      (q_valid),
        .i_op            (queue_op),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- sim/tb_register_alu_execute_unit.sv -----
// Self-checking testbench of the register ALU execute unit: directed rows, then random traffic.
module tb_register_alu_execute_unit;
    import raeu_pkg::*;

    // Mode codes outside the instruction set; the block must reject them.
    localparam logic [3:0] MODE_SPARE_LO = 4'd14;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    localparam int RANDOM_ITEMS    = 2000;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int NUM_DIRECTED    = 27;

    // One result beat as it appears on the master side.
    typedef struct packed {
        logic [RAEU_DATA_W-1:0]  dst_value;
        logic [RAEU_DATA_W-1:0]  src_value;
        logic [RAEU_FLAGS_W-1:0] flags;
        logic                    accepted;
        logic                    divide_error;
    } t_alu_result;

    // One directed instruction; typed rows carry their expected result.
    typedef struct packed {
        logic [3:0]             mode;
        logic [3:0]             dst;
        logic [3:0]             src;
        logic [RAEU_DATA_W-1:0] imm;
        logic                   typed;
        t_alu_result            want;
    } t_stim_row;

    localparam t_alu_result FROM_PREDICTOR = '0;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_axis_tvalid;
    logic                        o_s_axis_tready;
    logic [RAEU_IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready;
    logic [RAEU_OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [RAEU_OUT_TUSER_W-1:0] o_m_axis_tuser;

    // Shadow copy of the architectural state.
    logic [RAEU_DATA_W-1:0]  shadow_regs [RAEU_NUM_REGS];
    logic [RAEU_FLAGS_W-1:0] shadow_flags;

    t_alu_result pending_results [$];

    int mismatch_count = 0;
    int sent_count     = 0;
    int executed_count = 0;
    int rejected_count = 0;
    int div_zero_count = 0;
    int checked_count  = 0;
    int sink_count     = 0;
    int idle_cycles    = 0;

    // Directed rows: extremes, every mode, rejections and the corner cases.
    t_stim_row directed_rows [NUM_DIRECTED] = '{
        '{MODE_SPARE_HI, 4'd8,  4'd8,  16'h0000, 1'b1, '{16'h0000, 16'h0000, 4'h0, 1'b0, 1'b0}},
        '{MODE_LDI,      4'd0,  4'd15, 16'h7FFF, 1'b1, '{16'h7FFF, 16'h0000, 4'h0, 1'b1, 1'b0}},
        '{MODE_LDI,      4'd1,  4'd0,  16'h8000, 1'b1, '{16'h8000, 16'h7FFF, 4'h0, 1'b1, 1'b0}},
        '{MODE_DIV,      4'd2,  4'd3,  16'h0000, 1'b1, '{16'h0000, 16'h0000, 4'h0, 1'b1, 1'b1}},
        '{MODE_ADD,      4'd0,  4'd1,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_LDI,      4'd2,  4'd0,  16'hFFFF, 1'b0, FROM_PREDICTOR},
        '{MODE_LDI,      4'd3,  4'd0,  16'h8000, 1'b0, FROM_PREDICTOR},
        '{MODE_DIV,      4'd3,  4'd2,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_SUB,      4'd1,  4'd0,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_MUL,      4'd0,  4'd1,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_CMP,      4'd3,  4'd1,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_CMP,      4'd0,  4'd0,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_NOT,      4'd4,  NOT_SRC_CODE, 16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_NOT,      4'd4,  4'd3,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_AND,      4'd4,  4'd2,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_OR,       4'd5,  4'd3,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_XOR,      4'd5,  4'd5,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_TEST,     4'd4,  4'd3,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_LDI,      4'd6,  4'd0,  16'h0010, 1'b0, FROM_PREDICTOR},
        '{MODE_SHL,      4'd3,  4'd6,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_SHR,      4'd2,  4'd6,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_XCHG,     4'd0,  4'd1,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_XCHG,     4'd7,  4'd7,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_SPARE_LO, 4'd0,  4'd0,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_ADD,      4'd15, 4'd0,  16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_SUB,      4'd0,  4'd12, 16'h0000, 1'b0, FROM_PREDICTOR},
        '{MODE_LDI,      4'd0,  4'd9,  16'h1234, 1'b0, FROM_PREDICTOR}
    };

    register_alu_execute_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Clock with a period of 20 time units.
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Executes one instruction on the shadow state and returns the result beat.
    function automatic t_alu_result execute_instr(input logic [3:0] mode,
                                                  input logic [3:0] di,
                                                  input logic [3:0] si,
                                                  input logic [RAEU_DATA_W-1:0] imm);
        t_alu_result res;
        logic dvalid, svalid, ok, dverr;
        logic [RAEU_DATA_W-1:0] d, s, r, t;
        logic signed [31:0] ds, ss, ts, quot;
        int unsigned amt;
        dvalid = di < RAEU_NUM_REGS;
        svalid = si < RAEU_NUM_REGS;
        dverr  = 1'b0;
        if (mode == MODE_NOT) begin
            ok = dvalid && (si == NOT_SRC_CODE);
        end else if (mode == MODE_LDI) begin
            ok = dvalid;
        end else if (mode <= MODE_XCHG) begin
            ok = dvalid && svalid;
        end else begin
            ok = 1'b0;
        end
        if (ok) begin
            d = shadow_regs[di[2:0]];
            s = (mode == MODE_NOT || mode == MODE_LDI) ? '0 : shadow_regs[si[2:0]];
            ds = {{16{d[15]}}, d};
            ss = {{16{s[15]}}, s};
            amt = 32'(s);
            r = d;
            case (mode)
                MODE_ADD: r = d + s;
                MODE_SUB: r = d - s;
                MODE_MUL: r = d * s;
                MODE_DIV: begin
                    if (s == '0) begin
                        dverr = 1'b1;
                    end else begin
                        // Truncates toward zero; the overflow case wraps back to -32768.
                        quot = ds / ss;
                        r = quot[15:0];
                    end
                end
                MODE_CMP: begin
                    t = d - s;
                    ts = {{16{t[15]}}, t};
                    shadow_flags = '0;
                    shadow_flags[FLAG_Z_BIT] = (t == '0);
                    shadow_flags[FLAG_N_BIT] = t[15];
                    shadow_flags[FLAG_C_BIT] = (s > d);
                    shadow_flags[FLAG_O_BIT] = (ss < 0 && ds > 0 && ts < 0) ||
                                               (ss > 0 && ds < 0 && ts > 0);
                end
                MODE_NOT: r = ~d;
                MODE_AND: r = d & s;
                MODE_OR:  r = d | s;
                MODE_XOR: r = d ^ s;
                MODE_TEST: begin
                    t = d & s;
                    if (t == '0) shadow_flags[FLAG_Z_BIT] = 1'b1;
                    if (t[15]) shadow_flags[FLAG_N_BIT] = 1'b1;
                end
                MODE_SHL: begin
                    r = (amt >= 16) ? '0 : d << amt;
                    if (amt >= 1 && amt <= 16 && d[16 - amt]) shadow_flags[FLAG_C_BIT] = 1'b1;
                    if (r == '0) shadow_flags[FLAG_Z_BIT] = 1'b1;
                    if (r[15]) shadow_flags[FLAG_N_BIT] = 1'b1;
                end
                MODE_SHR: begin
                    // Kept as a separate statement so the shift stays arithmetic.
                    if (amt >= 16) r = {16{d[15]}};
                    else r = $signed(d) >>> amt;
                    if (amt >= 1 && amt <= 15 && d[amt - 1]) shadow_flags[FLAG_C_BIT] = 1'b1;
                    if (r == '0) shadow_flags[FLAG_Z_BIT] = 1'b1;
                    if (r[15]) shadow_flags[FLAG_N_BIT] = 1'b1;
                end
                MODE_XCHG: begin
                    shadow_regs[si[2:0]] = d;
                    r = s;
                end
                default: r = imm;
            endcase
            shadow_regs[di[2:0]] = r;
        end
        res.dst_value    = dvalid ? shadow_regs[di[2:0]] : '0;
        res.src_value    = svalid ? shadow_regs[si[2:0]] : '0;
        res.flags        = shadow_flags;
        res.accepted     = ok;
        res.divide_error = dverr;
        return res;
    endfunction

    // Sends one instruction beat after a random gap and queues its expected result.
    task automatic send_instr(input logic [3:0] mode, input logic [3:0] di,
                              input logic [3:0] si, input logic [RAEU_DATA_W-1:0] imm,
                              input logic typed, input t_alu_result want);
        int gap;
        t_alu_result predicted;
        // Every third stretch of beats runs back to back.
        gap = (((sent_count / 150) % 3) == 2) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0000, imm, si, di, mode};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = execute_instr(mode, di, si, imm);
        pending_results.push_back(typed ? want : predicted);
        sent_count++;
        if (predicted.accepted) executed_count++;
        else rejected_count++;
        if (predicted.divide_error) div_zero_count++;
    endtask

    // Result sink with random stalls and stretches without any.
    initial begin : result_sink
        int stall;
        i_m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = (((sink_count / 120) % 3) == 1) ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            sink_count++;
        end
    end

    // Compare every result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_alu_result exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no instruction outstanding");
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                checked_count++;
                if (o_m_axis_tdata[15:0] !== exp_res.dst_value) begin
                    $error("dst_value: expected %h, got %h", exp_res.dst_value,
                           o_m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[31:16] !== exp_res.src_value) begin
                    $error("src_value: expected %h, got %h", exp_res.src_value,
                           o_m_axis_tdata[31:16]);
                    mismatch_count++;
                end
                if (o_m_axis_tdata[35:32] !== exp_res.flags) begin
                    $error("flags: expected %b, got %b", exp_res.flags, o_m_axis_tdata[35:32]);
                    mismatch_count++;
                end
                if (o_m_axis_tuser[0] !== exp_res.accepted) begin
                    $error("accepted: expected %b, got %b", exp_res.accepted, o_m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (o_m_axis_tuser[1] !== exp_res.divide_error) begin
                    $error("divide_error: expected %b, got %b", exp_res.divide_error,
                           o_m_axis_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any beat.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d results outstanding.", pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, random instructions, drain.
    initial begin : stimulus
        logic [3:0] mode, di, si;
        logic [RAEU_DATA_W-1:0] imm;
        int roll;
        for (int i = 0; i < RAEU_NUM_REGS; i++) shadow_regs[i] = '0;
        shadow_flags = '0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_instr(directed_rows[i].mode, directed_rows[i].dst, directed_rows[i].src,
                       directed_rows[i].imm, directed_rows[i].typed, directed_rows[i].want);
        end

        // Mostly valid instructions; loads are common to keep small shift amounts and zeros.
        while (sent_count < NUM_DIRECTED + RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
            else if (roll < 18) mode = MODE_LDI;
            else mode = 4'($urandom_range(0, 13));
            di = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) :
                                               4'($urandom_range(0, 7));
            si = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15)) :
                                               4'($urandom_range(0, 7));
            if (mode == MODE_NOT && $urandom_range(0, 7) != 0) si = NOT_SRC_CODE;
            case ($urandom_range(0, 3))
                0: imm = 16'($urandom_range(0, 20));
                1: begin
                    case ($urandom_range(0, 4))
                        0: imm = 16'h0000;
                        1: imm = 16'h0001;
                        2: imm = 16'h7FFF;
                        3: imm = 16'h8000;
                        default: imm = 16'hFFFF;
                    endcase
                end
                default: imm = 16'($urandom);
            endcase
            send_instr(mode, di, si, imm, 1'b0, FROM_PREDICTOR);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d instructions: %0d executed, %0d rejected, %0d divisions by zero.",
                 sent_count, executed_count, rejected_count, div_zero_count);
        $display("Checked %0d results, field mismatches found: %0d.",
                 checked_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/raeu_pkg.sv
hw/rtl/raeu_front.sv
hw/rtl/raeu_queue.sv
hw/rtl/raeu_div.sv
hw/rtl/raeu_back.sv
hw/rtl/register_alu_execute_unit.sv
sim/tb_register_alu_execute_unit.sv
